// ----- rtl/core/assert_macros.svh -----
// Assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ----- rtl/core/icf_pkg.sv -----
// ----------------------------------------------------------------------------
// icf_pkg
// Shared opcodes, widths and types of the constant folder.
// ----------------------------------------------------------------------------
package icf_pkg;
    localparam int VREGS_DEF = 256;
    localparam int CFG_W     = 9;
    localparam int VAL_W     = 64;

    typedef enum logic [4:0] {
        OP_IMM = 5'd0, OP_MOV = 5'd1, OP_ADD = 5'd2, OP_SUB = 5'd3, OP_MUL = 5'd4,
        OP_DIV = 5'd5, OP_MOD = 5'd6, OP_EQ = 5'd7, OP_NEQ = 5'd8, OP_LT = 5'd9,
        OP_GT = 5'd10, OP_LTE = 5'd11, OP_GTE = 5'd12, OP_AND = 5'd13,
        OP_OR = 5'd14, OP_XOR = 5'd15, OP_SHL = 5'd16, OP_SHR = 5'd17,
        OP_NEG = 5'd18, OP_NOT = 5'd19, OP_BITNOT = 5'd20, OP_BARRIER = 5'd21,
        OP_OTHER = 5'd22
    } t_op;

    // Front-end classification handed to the back end
    typedef struct packed {
        logic [4:0]       op;
        logic             dok;
        logic             aok;
        logic             bok;
        logic [7:0]       d;
        logic [7:0]       a;
        logic [7:0]       b;
        logic [VAL_W-1:0] imm;
        logic             last;
    } t_cmd;
endpackage

// ----- rtl/core/icf_ram.sv -----
// ----------------------------------------------------------------------------
// icf_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module icf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- rtl/core/icf_front.sv -----
// ----------------------------------------------------------------------------
// icf_front
// Accept instructions, check register indices, push commands to the queue.
// ----------------------------------------------------------------------------
module icf_front
    import icf_pkg::*;
#(
    parameter int VREGS = VREGS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [4:0]       i_op,
    input  logic [8:0]       i_dest,
    input  logic [8:0]       i_sa,
    input  logic [8:0]       i_sb,
    input  logic [VAL_W-1:0] i_imm,
    input  logic             i_last,
    output logic             o_valid,
    input  logic             i_ready,
    output t_cmd             o_cmd
);
    localparam int QD = 2;
    logic [CFG_W-1:0] r_lim;
    t_cmd             r_q [QD];
    logic [1:0]       r_cnt;
    logic             r_rp, r_wp;
    logic             push, pop;
    t_cmd             c;
    logic [12:0]      lim_e;

    // Effective limit: min(vregs_in_use, VREGS)
    assign lim_e = (13'(r_lim) < 13'(VREGS)) ? 13'(r_lim) : 13'(VREGS);

    function automatic logic idx_ok(input logic [8:0] f, input logic [12:0] l);
        return !f[8] && (13'(f[7:0]) < l);
    endfunction

    always_comb begin
        c.op   = i_op;
        c.dok  = idx_ok(i_dest, lim_e);
        c.aok  = idx_ok(i_sa, lim_e);
        c.bok  = idx_ok(i_sb, lim_e);
        c.d    = i_dest[7:0];
        c.a    = i_sa[7:0];
        c.b    = i_sb[7:0];
        c.imm  = i_imm;
        c.last = i_last;
    end

    assign o_ready = (r_cnt != 2'(QD));
    assign push    = i_valid && o_ready;
    assign o_valid = (r_cnt != 2'd0);
    assign pop     = o_valid && i_ready;
    assign o_cmd   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim <= CFG_W'(256);
            r_cnt <= '0;
            r_rp  <= 1'b0;
            r_wp  <= 1'b0;
        end else begin
            if (i_cfg_we) r_lim <= i_cfg_wdata;
            if (push) begin
                r_q[r_wp] <= c;
                r_wp      <= ~r_wp;
            end
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end
endmodule

// ----- rtl/core/icf_div.sv -----
// ----------------------------------------------------------------------------
// icf_div
// Radix-2 signed divider: one quotient bit a cycle, truncating quotient.
// ----------------------------------------------------------------------------
module icf_div
    import icf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [VAL_W-1:0] i_a,
    input  logic [VAL_W-1:0] i_b,
    output logic             o_done,
    output logic [VAL_W-1:0] o_quo,
    output logic [VAL_W-1:0] o_rem
);
    logic [VAL_W-1:0] r_q, r_r, r_d;
    logic [6:0]       r_n;
    logic             r_busy, r_qs, r_rs;
    logic [VAL_W:0]   t;
    logic [VAL_W-1:0] ma, mb;

    assign ma = i_a[VAL_W-1] ? -i_a : i_a;
    assign mb = i_b[VAL_W-1] ? -i_b : i_b;
    assign t  = {r_r, r_q[VAL_W-1]} - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_q    <= ma;
                r_r    <= '0;
                r_d    <= mb;
                r_n    <= 7'd0;
                r_qs   <= i_a[VAL_W-1] ^ i_b[VAL_W-1];
                r_rs   <= i_a[VAL_W-1];
            end else if (r_busy) begin
                // Shift and subtract one bit
                if (!t[VAL_W]) r_r <= t[VAL_W-1:0];
                else r_r <= {r_r[VAL_W-2:0], r_q[VAL_W-1]};
                r_q <= {r_q[VAL_W-2:0], ~t[VAL_W]};
                r_n <= r_n + 7'd1;
                if (r_n == 7'(VAL_W - 1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_quo = r_qs ? -r_q : r_q;
    assign o_rem = r_rs ? -r_r : r_r;
endmodule

// ----- rtl/core/icf_back.sv -----
// ----------------------------------------------------------------------------
// icf_back
// Read the table, fold the operation, update flags and values, emit a result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module icf_back
    import icf_pkg::*;
#(
    parameter int VREGS = VREGS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_cmd             i_cmd,
    output logic             o_valid,
    input  logic             i_ready,
    output logic             o_folded,
    output logic [VAL_W-1:0] o_value,
    output logic             o_last
);
    localparam int AW = $clog2(VREGS);
    typedef enum logic [2:0] {S_IDLE, S_READ, S_EXEC, S_MUL, S_DIV, S_OUT} t_state;

    t_state           r_state;
    t_cmd             r_cmd;
    logic [VREGS-1:0] r_flag;
    logic [VAL_W-1:0] r_mul, r_val;
    logic [1:0]       r_mstep;
    logic             r_fold, r_dstart, r_wdone;
    logic [VAL_W-1:0] va, vb, dq, dr, res;
    logic             ddone, fa, fb;
    logic             we;
    logic [VAL_W-1:0] wdata;
    logic [AW-1:0]    ad, aa, ab;
    logic [5:0]       sh;
    logic [7:0]       d8;
    logic [31:0]      mx, my;
    logic [63:0]      mp;

    assign d8 = r_cmd.d;
    assign ad = AW'(d8);
    assign aa = AW'(r_cmd.a);
    assign ab = AW'(r_cmd.b);

    icf_ram #(.WIDTH(VAL_W), .DEPTH(VREGS)) u_ram_a (
        .i_clk(i_clk), .i_we(we), .i_waddr(ad), .i_wdata(wdata),
        .i_raddr(aa), .o_rdata(va)
    );
    icf_ram #(.WIDTH(VAL_W), .DEPTH(VREGS)) u_ram_b (
        .i_clk(i_clk), .i_we(we), .i_waddr(ad), .i_wdata(wdata),
        .i_raddr(ab), .o_rdata(vb)
    );
    icf_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_dstart), .i_a(va), .i_b(vb),
        .o_done(ddone), .o_quo(dq), .o_rem(dr)
    );

    assign fa = r_cmd.aok && r_flag[AW'(r_cmd.a)];
    assign fb = r_cmd.bok && r_flag[AW'(r_cmd.b)];
    assign sh = vb[5:0];
    assign o_ready = (r_state == S_IDLE);

    // Low 64 bits of the product from three 32x32 partial products
    assign mx = (r_mstep == 2'd2) ? va[63:32] : va[31:0];
    assign my = (r_mstep == 2'd1) ? vb[63:32] : vb[31:0];
    assign mp = 64'(mx) * 64'(my);

    always_comb begin
        res = '0;
        unique case (r_cmd.op)
            OP_ADD:    res = va + vb;
            OP_SUB:    res = va - vb;
            OP_AND:    res = va & vb;
            OP_OR:     res = va | vb;
            OP_XOR:    res = va ^ vb;
            OP_EQ:     res = VAL_W'(va == vb);
            OP_NEQ:    res = VAL_W'(va != vb);
            OP_LT:     res = VAL_W'($signed(va) < $signed(vb));
            OP_GT:     res = VAL_W'($signed(va) > $signed(vb));
            OP_LTE:    res = VAL_W'($signed(va) <= $signed(vb));
            OP_GTE:    res = VAL_W'($signed(va) >= $signed(vb));
            OP_SHL:    res = va << sh;
            OP_SHR:    res = VAL_W'($signed(va) >>> sh);
            OP_MOV:    res = va;
            OP_NEG:    res = -va;
            OP_NOT:    res = VAL_W'(va == '0);
            OP_BITNOT: res = ~va;
            default:   res = '0;
        endcase
    end

    // Table write for the current instruction, done once at its end
    assign we    = (r_state == S_OUT) && !r_wdone && r_cmd.dok &&
                   (r_fold || r_cmd.op == OP_IMM);
    assign wdata = r_fold ? r_val : r_cmd.imm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_flag   <= '0;
            o_valid  <= 1'b0;
            r_dstart <= 1'b0;
            r_wdone  <= 1'b0;
        end else begin
            r_dstart <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_valid) begin
                    r_cmd   <= i_cmd;
                    r_state <= S_READ;
                end
                S_READ: r_state <= S_EXEC;
                S_EXEC: begin
                    r_fold <= 1'b0;
                    r_val  <= '0;
                    r_state <= S_OUT;
                    priority if (!r_cmd.dok || r_cmd.op == OP_IMM
                                 || r_cmd.op == OP_BARRIER) begin
                    end else if (r_cmd.op == OP_MOV || r_cmd.op == OP_NEG
                                 || r_cmd.op == OP_NOT || r_cmd.op == OP_BITNOT) begin
                        r_fold <= fa;
                        r_val  <= fa ? res : '0;
                    end else if (r_cmd.op == OP_MUL) begin
                        r_mstep <= 2'd0;
                        r_state <= S_MUL;
                    end else if (r_cmd.op == OP_DIV || r_cmd.op == OP_MOD) begin
                        if (fa && fb && vb != '0) begin
                            r_dstart <= 1'b1;
                            r_state  <= S_DIV;
                        end
                    end else if (r_cmd.op >= OP_ADD && r_cmd.op <= OP_SHR) begin
                        r_fold <= fa && fb;
                        r_val  <= (fa && fb) ? res : '0;
                    end else begin
                    end
                end
                S_MUL: begin
                    r_mstep <= r_mstep + 2'd1;
                    unique case (r_mstep)
                        2'd0: r_mul <= mp;
                        2'd1: r_mul[63:32] <= r_mul[63:32] + mp[31:0];
                        default: begin
                            r_fold  <= fa && fb;
                            r_val   <= (fa && fb) ?
                                       {r_mul[63:32] + mp[31:0], r_mul[31:0]} : '0;
                            r_state <= S_OUT;
                        end
                    endcase
                end
                S_DIV: if (ddone) begin
                    r_fold  <= 1'b1;
                    r_val   <= (r_cmd.op == OP_DIV) ? dq : dr;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_wdone) begin
                        r_wdone  <= 1'b1;
                        o_valid  <= 1'b1;
                        o_folded <= r_fold;
                        o_value  <= r_val;
                        o_last   <= r_cmd.last;
                        if (r_cmd.op == OP_BARRIER || r_cmd.last) r_flag <= '0;
                        else if (r_cmd.dok) r_flag[ad] <= r_fold || r_cmd.op == OP_IMM;
                    end else if (i_ready) begin
                        o_valid <= 1'b0;
                        r_wdone <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `ASSERT_IMPL(a_val_hold, i_clk, i_rst_n, (o_valid && !i_ready) |=> $stable(o_value))
    `ASSERT_NEVER(a_fold_dok, i_clk, i_rst_n, o_valid && o_folded && !r_cmd.dok)
    `ASSERT_NEVER(a_unfolded_zero, i_clk, i_rst_n, o_valid && !o_folded && o_value != '0)
    `ASSERT_IMPL(a_div_start, i_clk, i_rst_n, r_dstart |-> r_state == S_DIV)
endmodule

// ----- rtl/core/ir_constant_folder.sv -----
// Sequence: front-end queue, then back-end read, execute and output states; mul adds
// a multiply state (three 32x32 partial products), div/mod a divide state (one bit
// per cycle in the radix-2 divider). The back end takes a new instruction only when
// idle, after the last result is accepted; output stalls hold it.
// Reset: synchronous active low; all constant flags clear at once, limit 256.
// ----------------------------------------------------------------------------
// ir_constant_folder
// Constant propagation and folding over a stream of IR instructions.
// ----------------------------------------------------------------------------
module ir_constant_folder
    import icf_pkg::*;
#(
    parameter int VREGS = VREGS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // opcode[4:0], dest_reg[13:5], src_a[22:14], src_b[31:23], imm_value[95:32]
    input  logic [95:0]      s_axis_tdata,
    input  logic             s_axis_tlast,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // folded_value[63:0]
    output logic [63:0]      m_axis_tdata,
    // folded[0]
    output logic             m_axis_tuser,
    output logic             m_axis_tlast
);
    logic q_valid, q_ready;
    t_cmd q_cmd;

    icf_front #(.VREGS(VREGS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata), .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_op(s_axis_tdata[4:0]), .i_dest(s_axis_tdata[13:5]),
        .i_sa(s_axis_tdata[22:14]), .i_sb(s_axis_tdata[31:23]),
        .i_imm(s_axis_tdata[95:32]), .i_last(s_axis_tlast),
        .o_valid(q_valid), .i_ready(q_ready), .o_cmd(q_cmd)
    );
    icf_back #(.VREGS(VREGS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_valid), .o_ready(q_ready),
        .i_cmd(q_cmd), .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_folded(m_axis_tuser), .o_value(m_axis_tdata), .o_last(m_axis_tlast)
    );
endmodule
